// ===== src/pidm_pkg.sv =====
// Package for the PWM input duty meter.
// Holds the item and result types, register indexes, sequencer states and constants.
// No dependencies.
package pidm_pkg;

  localparam int NUM_W      = 26;
  localparam int DIVISOR_W  = 16;
  localparam int COUNT_W    = 8;
  localparam int DUTY_W     = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [9:0]         DUTY_SCALE = 10'd1000;
  localparam logic [2:0]         DUTY_ROUND = 3'd5;
  localparam logic [DUTY_W-1:0]  DUTY_MAX   = 10'd1023;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PERIOD  = 8'd3;

  localparam logic [COUNT_W-1:0]    STUCK_LIMIT_RESET    = 8'd5;
  localparam logic [DUTY_W-1:0]     FULL_DUTY_RESET      = 10'd1000;
  localparam logic [DUTY_W-1:0]     ZERO_DUTY_RESET      = 10'd0;
  localparam logic [DIVISOR_W-1:0]  DEFAULT_PERIOD_RESET = 16'd4800;

  typedef struct packed {
    logic        capture_event;
    logic        overflow_event;
    logic        pin_level;
    logic [15:0] captured_high_time;
    logic [15:0] captured_period;
    logic        evaluate;
  } meas_item_t;

  typedef struct packed {
    logic [9:0]  duty_permille;
    logic [15:0] period_count;
    logic        stuck_detected;
  } meas_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== src/pidm_div.sv =====
// Restoring serial divider for the PWM input duty meter, one quotient bit per cycle.
// Depends on pidm_pkg for the operand widths.
module pidm_div
  import pidm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_W-1:0]     numer,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [NUM_W-1:0]     quot
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic [NUM_W-1:0]     quo_sh;
  logic [DIVISOR_W-1:0] rem;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign rem_sh = {rem, quo_sh[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign diff   = rem_sh - {1'b0, divisor};
  assign quot   = quo_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= numer;
      rem    <= '0;
    end else if (busy) begin
      rem    <= ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_sh <= {quo_sh[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== src/pwm_input_duty_meter.sv =====
// PWM input duty meter: one result item for every input item.
// An item without evaluation goes from ST_IDLE to ST_DONE; one whose stored high time or
// period is zero passes ST_LOAD to ST_DONE; one that computes the duty also waits in ST_DIV
// for the 26 steps of the serial divider. The block takes no new item while one is at work,
// and a finished result waits in an output register until it is taken, adding stall cycles.
// Depends on pidm_pkg and pidm_div.
module pwm_input_duty_meter
  import pidm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  meas_item_t            item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output meas_result_t          result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state;
  state_t state_next;

  logic [COUNT_W-1:0]   stuck_limit;
  logic [DUTY_W-1:0]    full_duty_value;
  logic [DUTY_W-1:0]    zero_duty_value;
  logic [DIVISOR_W-1:0] default_period;

  logic                 capture_seen;
  logic [15:0]          high_time;
  logic [15:0]          period_store;
  logic [COUNT_W-1:0]   high_stuck_count;
  logic [COUNT_W-1:0]   low_stuck_count;
  logic [DUTY_W-1:0]    duty_store;
  logic                 eval_pending;
  logic                 div_ran;

  logic                 accept;
  logic                 out_free;
  logic                 operands_ok;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     numer;
  logic [NUM_W-1:0]     quot;
  logic [DUTY_W-1:0]    duty_calc;
  logic                 stuck;
  logic                 finish;
  logic                 seen_after_cap;

  assign accept      = item_valid && item_ready;
  assign out_free    = !result_valid || result_ready;
  assign operands_ok = (high_time != '0) && (period_store != '0);
  assign cfg_ready   = !rst;

  assign numer = NUM_W'(high_time) * NUM_W'(DUTY_SCALE)
               + NUM_W'(period_store) * NUM_W'(DUTY_ROUND);

  assign duty_calc = !div_ran ? duty_store
                   : (quot[NUM_W-1:DUTY_W] != '0) ? DUTY_MAX : quot[DUTY_W-1:0];

  assign stuck = eval_pending
              && ((high_stuck_count > stuck_limit) || (low_stuck_count > stuck_limit));

  assign seen_after_cap = item.capture_event || capture_seen;

  pidm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .numer   (numer),
    .divisor (period_store),
    .done    (div_done),
    .quot    (quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = item.evaluate ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        state_next = operands_ok ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    div_start  = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: item_ready = !rst;
      ST_LOAD: div_start  = operands_ok;
      ST_DIV:  ;
      ST_DONE: finish     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stuck_limit     <= STUCK_LIMIT_RESET;
      full_duty_value <= FULL_DUTY_RESET;
      zero_duty_value <= ZERO_DUTY_RESET;
      default_period  <= DEFAULT_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STUCK_LIMIT:    stuck_limit     <= cfg_data[COUNT_W-1:0];
        REG_FULL_DUTY:      full_duty_value <= cfg_data[DUTY_W-1:0];
        REG_ZERO_DUTY:      zero_duty_value <= cfg_data[DUTY_W-1:0];
        REG_DEFAULT_PERIOD: default_period  <= cfg_data[DIVISOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_seen     <= 1'b0;
      high_time        <= '0;
      period_store     <= '0;
      high_stuck_count <= '0;
      low_stuck_count  <= '0;
      duty_store       <= '0;
      eval_pending     <= 1'b0;
      div_ran          <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        eval_pending <= item.evaluate;
        div_ran      <= 1'b0;
        if (item.capture_event) begin
          high_time        <= item.captured_high_time;
          period_store     <= item.captured_period;
          high_stuck_count <= '0;
          low_stuck_count  <= '0;
        end
        if (item.overflow_event) begin
          capture_seen <= 1'b0;
          if (seen_after_cap) begin
            high_stuck_count <= '0;
            low_stuck_count  <= '0;
          end else if (item.pin_level) begin
            if (high_stuck_count != COUNT_MAX) begin
              high_stuck_count <= high_stuck_count + 1'b1;
            end
            low_stuck_count <= '0;
          end else begin
            if (low_stuck_count != COUNT_MAX) begin
              low_stuck_count <= low_stuck_count + 1'b1;
            end
            high_stuck_count <= '0;
          end
        end else begin
          capture_seen <= seen_after_cap;
        end
      end
      if (div_start) begin
        div_ran <= 1'b1;
      end
      if (finish) begin
        result_valid <= 1'b1;
        if (stuck) begin
          duty_store       <= (high_stuck_count > low_stuck_count) ? full_duty_value
                                                                   : zero_duty_value;
          period_store     <= default_period;
          high_stuck_count <= '0;
          low_stuck_count  <= '0;
          high_time        <= '0;
        end else begin
          duty_store <= duty_calc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.duty_permille  <= stuck ? ((high_stuck_count > low_stuck_count)
                                        ? full_duty_value : zero_duty_value)
                                     : duty_calc;
      result.period_count   <= stuck ? default_period : period_store;
      result.stuck_detected <= stuck;
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("Divider finished outside the divide state.");

  a_one_counter: assert property (@(posedge clk) disable iff (rst)
    (high_stuck_count != '0) |-> (low_stuck_count == '0))
    else $error("Both stuck counters are nonzero.");

  a_stuck_clears: assert property (@(posedge clk) disable iff (rst)
    (finish && stuck) |=> (high_stuck_count == '0) && (low_stuck_count == '0)
                          && (high_time == '0) && result.stuck_detected)
    else $error("Stuck detection did not clear the measurement state.");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !accept)
    else $error("Item accepted while a previous item is at work.");
`endif

endmodule

// ===== tb/duty_meter_checker.sv =====
`timescale 1ns / 1ps
// Checker for the PWM input duty meter: watches the item, result and register write channels.
// It predicts every result from its own copy of the state and compares field by field.
// Depends on pidm_pkg.
module duty_meter_checker
  import pidm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  meas_item_t            item,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  meas_result_t          result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    outstanding,
  output int                    mismatches
);

  logic [COUNT_W-1:0]   limit_cfg;
  logic [DUTY_W-1:0]    full_cfg;
  logic [DUTY_W-1:0]    zero_cfg;
  logic [DIVISOR_W-1:0] dflt_period_cfg;

  logic                 seen_capture;
  logic [15:0]          high_time_q;
  logic [15:0]          period_q;
  logic [COUNT_W-1:0]   high_run;
  logic [COUNT_W-1:0]   low_run;
  logic [DUTY_W-1:0]    duty_q;

  meas_result_t expected_readings[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic meas_result_t predict_reading(input meas_item_t it);
    int unsigned  numer;
    int unsigned  quot;
    meas_result_t r;
    r.stuck_detected = 1'b0;
    if (it.capture_event) begin
      seen_capture = 1'b1;
      high_time_q  = it.captured_high_time;
      period_q     = it.captured_period;
      high_run     = '0;
      low_run      = '0;
    end
    if (it.overflow_event) begin
      if (!seen_capture) begin
        if (it.pin_level) begin
          high_run = (high_run == COUNT_MAX) ? COUNT_MAX : high_run + 1'b1;
          low_run  = '0;
        end else begin
          low_run  = (low_run == COUNT_MAX) ? COUNT_MAX : low_run + 1'b1;
          high_run = '0;
        end
      end else begin
        high_run = '0;
        low_run  = '0;
      end
      seen_capture = 1'b0;
    end
    if (it.evaluate) begin
      if (period_q != 0 && high_time_q != 0) begin
        numer  = 32'(high_time_q) * 32'(DUTY_SCALE) + 32'(period_q) * 32'(DUTY_ROUND);
        quot   = numer / 32'(period_q);
        duty_q = (quot > 32'(DUTY_MAX)) ? DUTY_MAX : quot[DUTY_W-1:0];
      end
      if (high_run > limit_cfg || low_run > limit_cfg) begin
        duty_q           = (high_run > low_run) ? full_cfg : zero_cfg;
        period_q         = dflt_period_cfg;
        high_run         = '0;
        low_run          = '0;
        high_time_q      = '0;
        r.stuck_detected = 1'b1;
      end
    end
    r.duty_permille = duty_q;
    r.period_count  = period_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    meas_result_t want;
    if (rst) begin
      limit_cfg       = STUCK_LIMIT_RESET;
      full_cfg        = FULL_DUTY_RESET;
      zero_cfg        = ZERO_DUTY_RESET;
      dflt_period_cfg = DEFAULT_PERIOD_RESET;
      seen_capture    = 1'b0;
      high_time_q     = '0;
      period_q        = '0;
      high_run        = '0;
      low_run         = '0;
      duty_q          = '0;
      expected_readings.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STUCK_LIMIT:    limit_cfg       = cfg_data[COUNT_W-1:0];
          REG_FULL_DUTY:      full_cfg        = cfg_data[DUTY_W-1:0];
          REG_ZERO_DUTY:      zero_cfg        = cfg_data[DUTY_W-1:0];
          REG_DEFAULT_PERIOD: dflt_period_cfg = cfg_data[DIVISOR_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready)
        expected_readings.push_back(predict_reading(item));
      if (result_valid && result_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, result);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (result.duty_permille !== want.duty_permille) begin
            $display("%0t: duty_permille expected %0d, got %0d", $time,
                     want.duty_permille, result.duty_permille);
            mismatches++;
          end
          if (result.period_count !== want.period_count) begin
            $display("%0t: period_count expected %0d, got %0d", $time,
                     want.period_count, result.period_count);
            mismatches++;
          end
          if (result.stuck_detected !== want.stuck_detected) begin
            $display("%0t: stuck_detected expected %0b, got %0b", $time,
                     want.stuck_detected, result.stuck_detected);
            mismatches++;
          end
        end
      end
      outstanding <= expected_readings.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the PWM input duty meter testbench: clock, reset, items and register writes.
// Depends on pidm_pkg, pwm_input_duty_meter and duty_meter_checker.
module tb_top;
  import pidm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = REG_DEFAULT_PERIOD + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_ALL_ONES = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  meas_item_t            item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  meas_result_t          result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    outstanding;
  int                    mismatches;
  logic                  steady = 1'b0;
  logic [COUNT_W-1:0]    limit_now = STUCK_LIMIT_RESET;

  pwm_input_duty_meter dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  duty_meter_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      result_ready = steady || ($urandom_range(99) >= 28);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic meas_item_t meas(input logic cap, input logic ovf, input logic pin,
                                      input logic [15:0] hi, input logic [15:0] per,
                                      input logic ev);
    meas_item_t it;
    it.capture_event      = cap;
    it.overflow_event     = ovf;
    it.pin_level          = pin;
    it.captured_high_time = hi;
    it.captured_period    = per;
    it.evaluate           = ev;
    return it;
  endfunction

  task automatic send_item(input meas_item_t it);
    while (!steady && $urandom_range(99) < 28) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item       = it;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    item_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_STUCK_LIMIT)
      limit_now = data[COUNT_W-1:0];
  endtask

  // Most items are capture items or runs of overflows at one pin level, some long enough to
  // cross the stuck limit; the rest are fully random.
  task automatic run_random(input int count);
    int          run_left;
    logic        run_pin;
    int unsigned per;
    logic [63:0] noise;
    meas_item_t  it;
    run_left = 0;
    run_pin  = 1'b0;
    repeat (count) begin
      noise = {$urandom, $urandom};
      it    = noise[$bits(meas_item_t)-1:0];
      if (run_left == 0 && $urandom_range(99) < 35) begin
        run_pin  = 1'($urandom);
        run_left = $urandom_range(1) ? $urandom_range(1, 8)
                                     : $urandom_range(1, int'(limit_now) + 3);
      end
      if (run_left > 0) begin
        it.capture_event  = 1'b0;
        it.overflow_event = 1'b1;
        it.pin_level      = run_pin;
        it.evaluate       = ($urandom_range(99) < 70);
        run_left--;
      end else if ($urandom_range(99) < 70) begin
        per = ($urandom_range(99) < 80) ? $urandom_range(1, 2000) : $urandom_range(65535);
        it.capture_event      = 1'b1;
        it.captured_period    = 16'(per);
        it.captured_high_time = ($urandom_range(99) < 85) ? 16'($urandom_range(per))
                                                          : 16'($urandom);
        it.overflow_event     = ($urandom_range(99) < 30);
        it.evaluate           = ($urandom_range(99) < 80);
      end
      send_item(it);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(meas(1'b1, 1'b0, 1'b0, 16'd500, 16'd1000, 1'b1));
    send_item(meas(1'b1, 1'b0, 1'b1, 16'd0, 16'd1000, 1'b1));
    send_item(meas(1'b1, 1'b0, 1'b0, 16'd100, 16'd0, 1'b1));
    send_item(meas(1'b1, 1'b0, 1'b1, 16'hFFFF, 16'd1, 1'b1));
    send_item(meas(1'b1, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(meas(1'b1, 1'b0, 1'b1, 16'd1, 16'hFFFF, 1'b1));
    send_item(meas(1'b1, 1'b1, 1'b1, 16'd300, 16'd600, 1'b1));
    send_item(meas(1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b1));
    repeat (7) send_item(meas(1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1));
    repeat (7) send_item(meas(1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b1));
    send_item(meas(1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0));
    send_item(meas(1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0));
    run_random(150);

    wait_idle();
    write_reg(REG_STUCK_LIMIT, 16'd0);
    write_reg(REG_FULL_DUTY, 16'd1023);
    write_reg(REG_ZERO_DUTY, 16'd0);
    write_reg(REG_DEFAULT_PERIOD, 16'hFFFF);
    run_random(155);

    wait_idle();
    write_reg(REG_STUCK_LIMIT, 16'd254);
    write_reg(REG_FULL_DUTY, 16'd0);
    write_reg(REG_ZERO_DUTY, 16'd1023);
    write_reg(REG_DEFAULT_PERIOD, 16'd0);
    run_random(155);

    wait_idle();
    write_reg(REG_STUCK_LIMIT, 16'hFFFF);
    write_reg(REG_FULL_DUTY, 16'($urandom));
    write_reg(REG_ZERO_DUTY, 16'($urandom));
    write_reg(REG_DEFAULT_PERIOD, 16'($urandom));
    run_random(155);

    wait_idle();
    write_reg(REG_STUCK_LIMIT, {8'($urandom), 8'($urandom_range(1, 10))});
    write_reg(REG_FULL_DUTY, 16'($urandom));
    write_reg(REG_ZERO_DUTY, 16'($urandom));
    write_reg(REG_DEFAULT_PERIOD, 16'($urandom));
    write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_ALL_ONES, 16'($urandom));
    run_random(155);

    wait_idle();
    write_reg(REG_STUCK_LIMIT, 16'd3);
    write_reg(REG_FULL_DUTY, 16'($urandom));
    write_reg(REG_ZERO_DUTY, 16'($urandom));
    write_reg(REG_DEFAULT_PERIOD, 16'($urandom));
    steady = 1'b1;
    run_random(155);
    steady = 1'b0;

    item_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
